/* rtl/ocp_pkg.sv */
package ocp_pkg;

    // result status codes
    localparam logic [1:0] STATUS_FOUND     = 2'd0;
    localparam logic [1:0] STATUS_NONE      = 2'd1;
    localparam logic [1:0] STATUS_MALFORMED = 2'd2;

    // register map, selected by paddr[2]
    localparam int          ADDR_W       = 3;
    localparam logic        REG_CODE_A   = 1'b0;
    localparam logic        REG_CODE_B   = 1'b1;
    localparam logic [15:0] CODE_A_RESET = 16'h0200;
    localparam logic [15:0] CODE_B_RESET = 16'h0203;

    // feature codes that carry a base comid
    typedef struct packed {
        logic [15:0] code_a;
        logic [15:0] code_b;
    } t_cfg;

    // one parse result
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] comid;
    } t_result;

endpackage

/* rtl/ocp_cfg_regs.sv */
module ocp_cfg_regs
    import ocp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [15:0] r_code_a;
    logic [15:0] r_code_b;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register writes on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_a <= CODE_A_RESET;
            r_code_b <= CODE_B_RESET;
        end else if (wr_en) begin
            if (paddr[2] == REG_CODE_A) begin
                r_code_a <= pwdata[15:0];
            end else begin
                r_code_b <= pwdata[15:0];
            end
        end
    end

    // read back
    always_comb begin
        case (paddr[2])
            REG_CODE_A: prdata = {16'h0000, r_code_a};
            REG_CODE_B: prdata = {16'h0000, r_code_b};
            default:    prdata = 32'h0000_0000;
        endcase
    end

    assign o_cfg.code_a = r_code_a;
    assign o_cfg.code_b = r_code_b;

endmodule

/* rtl/ocp_parser.sv */
module ocp_parser
    import ocp_pkg::*;
#(
    parameter int MAX_LEN      = 2048,
    parameter int HEADER_BYTES = 48
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_go,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  t_cfg       i_cfg,
    output t_result    o_res
);

    localparam int              PW      = $clog2(MAX_LEN + 2);
    localparam logic [PW-1:0]   POS_MAX = PW'(MAX_LEN);
    localparam logic [31:0]     HDR_LEN = 32'(HEADER_BYTES);

    typedef enum logic [2:0] {
        PH_CODE_HI,
        PH_CODE_LO,
        PH_VERSION,
        PH_LENGTH,
        PH_BODY
    } t_phase;

    t_phase      r_phase,  n_phase;
    logic [PW-1:0] r_pos,  n_pos;
    logic [31:0] r_total,  n_total;
    logic [15:0] r_code,   n_code;
    logic [7:0]  r_remain, n_remain;
    logic [1:0]  r_seen,   n_seen;
    logic [7:0]  r_cand,   n_cand;
    logic        r_found,  n_found;
    logic        r_malf,   n_malf;
    logic [15:0] r_stored, n_stored;

    logic [31:0] pos32;
    logic        at_max;
    logic        parse_en;
    logic        overrun;
    logic        code_hit;
    logic        match;
    logic        bad_end;

    always_comb begin
        pos32    = 32'(r_pos);
        at_max   = r_pos >= POS_MAX;
        parse_en = !at_max && !r_malf && (pos32 >= HDR_LEN) && (pos32 < r_total);
        // body would run past the total length
        overrun  = (33'(pos32) + 33'(i_byte) + 33'd1) > {1'b0, r_total};
        code_hit = (r_code == i_cfg.code_a) || (r_code == i_cfg.code_b);
        // second body byte of a matching descriptor with at least 4 body bytes
        match    = parse_en && (r_phase == PH_BODY) && (r_seen == 2'd1) && code_hit
                   && (r_remain >= 8'd3);

        n_total  = (r_pos < PW'(4)) ? {r_total[23:0], i_byte} : r_total;
        n_pos    = (r_pos <= POS_MAX) ? r_pos + PW'(1) : r_pos;
        n_phase  = r_phase;
        n_code   = r_code;
        n_remain = r_remain;
        n_seen   = r_seen;
        n_cand   = r_cand;
        n_found  = r_found || match;
        n_stored = match ? {r_cand, i_byte} : r_stored;
        n_malf   = r_malf || at_max || (parse_en && (r_phase == PH_LENGTH) && overrun);

        // descriptor walk
        if (parse_en) begin
            case (r_phase)
                PH_CODE_HI: begin
                    n_code[15:8] = i_byte;
                    n_phase      = PH_CODE_LO;
                end
                PH_CODE_LO: begin
                    n_code[7:0] = i_byte;
                    n_phase     = PH_VERSION;
                end
                PH_VERSION: begin
                    n_phase = PH_LENGTH;
                end
                PH_LENGTH: begin
                    if (overrun) begin
                        n_phase = PH_LENGTH;
                    end else if (i_byte == 8'd0) begin
                        n_phase = PH_CODE_HI;
                    end else begin
                        n_remain = i_byte;
                        n_seen   = 2'd0;
                        n_phase  = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (r_seen == 2'd0) begin
                        n_cand = i_byte;
                    end
                    if (r_seen != 2'd2) begin
                        n_seen = r_seen + 2'd1;
                    end
                    n_remain = r_remain - 8'd1;
                    if (r_remain == 8'd1) begin
                        n_phase = PH_CODE_HI;
                    end
                end
                default: begin
                    n_phase = PH_CODE_HI;
                end
            endcase
        end

        // end of response checks
        bad_end = n_malf || (32'(n_pos) < HDR_LEN) || (n_total < HDR_LEN)
                  || (n_total > 32'(n_pos)) || (n_phase != PH_CODE_HI);

        if (bad_end) begin
            o_res.status = STATUS_MALFORMED;
            o_res.comid  = 16'h0000;
        end else if (n_found) begin
            o_res.status = STATUS_FOUND;
            o_res.comid  = n_stored;
        end else begin
            o_res.status = STATUS_NONE;
            o_res.comid  = 16'h0000;
        end
    end

    // parser state, cleared by reset and after the final beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_go && i_last)) begin
            r_phase  <= PH_CODE_HI;
            r_pos    <= '0;
            r_total  <= '0;
            r_code   <= '0;
            r_remain <= '0;
            r_seen   <= '0;
            r_cand   <= '0;
            r_found  <= 1'b0;
            r_malf   <= 1'b0;
            r_stored <= '0;
        end else if (i_go) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_total  <= n_total;
            r_code   <= n_code;
            r_remain <= n_remain;
            r_seen   <= n_seen;
            r_cand   <= n_cand;
            r_found  <= n_found;
            r_malf   <= n_malf;
            r_stored <= n_stored;
        end
    end

endmodule

/* rtl/opal_discovery_comid_parser_core.sv */
// channel  | valid       | stall       | payload
// ---------+-------------+-------------+----------------------------------
// in       | i_in_valid  | o_in_stall  | i_data_byte, i_last_byte
// out      | o_out_valid | i_out_stall | o_parse_status, o_comid
// config   | psel/penable| pready = 1  | paddr, pwdata, prdata
//
// one byte per cycle while the input is not stalled; a beat waits in the input
// register, and the parse state (and for a final byte the result register) update as it moves on
// a result passes through the input register and then the result register
// synchronous active-low reset clears the parse state and restores the codes
// the input stalls only when a final byte waits on a stalled, full result
module opal_discovery_comid_parser_core
    import ocp_pkg::*;
#(
    parameter int MAX_LEN      = 2048,
    parameter int HEADER_BYTES = 48
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_parse_status,
    output logic [15:0]       o_comid,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg        cfg;
    t_result     res;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic [15:0] r_out_comid;
    logic        go;
    logic        in_take;

    ocp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // the held beat moves on unless it is final and the result is blocked
    assign go         = r_in_valid && (!r_in_last || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !go;
    assign in_take    = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    ocp_parser #(
        .MAX_LEN      (MAX_LEN),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && r_in_last) begin
            r_out_status <= res.status;
            r_out_comid  <= res.comid;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_parse_status = r_out_status;
    assign o_comid        = r_out_comid;

endmodule

/* rtl/ocp_checker.sv */
module ocp_checker
    import ocp_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              i_last_byte,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [1:0]        o_parse_status,
    input logic [15:0]       o_comid
);

    // reset empties the result register
    assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_parse_status)
            && $stable(o_comid))
        else $error("stalled result changed");

    // comid is zero unless found
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_parse_status != STATUS_FOUND) |-> o_comid == 16'h0000)
        else $error("comid set without a match");

    // a new result follows an accepted final byte through the input and result registers
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall && i_last_byte, 2))
        else $error("result without a final byte");

    // input back-pressure only comes from a blocked result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with result side free");

endmodule

bind opal_discovery_comid_parser_core ocp_checker u_ocp_checker (.*);
